### hdl/packed_bitfield_row_unpacker_top_macros.svh
// Assertion macros shared by the row unpacker modules.
`ifndef PACKED_BITFIELD_ROW_UNPACKER_TOP_MACROS_SVH
`define PACKED_BITFIELD_ROW_UNPACKER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PBRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("row unpacker assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PBRU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("row unpacker assertion failed");

`endif

### hdl/pbru_pkg.sv
// Shared constants and types of the packed bit-field row unpacker.
`default_nettype none
package pbru_pkg;

  localparam int unsigned Groups       = 4;
  localparam int unsigned GroupsMax    = (Groups < 4) ? Groups : 4;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned NumW         = 8 + FracBits;
  localparam int unsigned DivCntW      = $clog2(NumW);
  localparam int unsigned MaxResults   = 8;
  localparam int unsigned DescW        = 25;

  // Field encodings.
  localparam logic [1:0] ENC_FRACTION = 2'd0;
  localparam logic [1:0] ENC_UNSIGNED = 2'd1;
  localparam logic [1:0] ENC_ONEHOT   = 2'd2;
  localparam logic [1:0] ENC_UNKNOWN  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GROUP_COUNT = 3'd0;
  localparam logic [2:0] CFG_DESC_A      = 3'd1;
  localparam logic [2:0] CFG_DESC_B      = 3'd2;
  localparam logic [2:0] CFG_DESC_C      = 3'd3;
  localparam logic [2:0] CFG_DESC_D      = 3'd4;

  localparam logic [2:0]       GroupCountReset = 3'd1;
  localparam logic [DescW-1:0] DescReset       = 25'd16809953;

  // Control of the bit-serial field shifter.
  typedef struct packed {
    logic load;   // load the accumulator from pending bits and the new byte
    logic start;  // begin a new field
    logic shift;  // move one bit from the accumulator into the field value
  } pbru_fs_ctrl_t;

endpackage
`default_nettype wire

### hdl/pbru_field_shift.sv
// Bit-serial accumulator that peels one field bit per cycle, LSB first.
`default_nettype none
module pbru_field_shift (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire pbru_pkg::pbru_fs_ctrl_t  ctrl_i,
  input  wire  [7:0]                    byte_i,
  input  wire  [7:0]                    pbits_i,
  input  wire  [3:0]                    pcnt_i,
  output logic [7:0]                    acc_lo_o,
  output logic [3:0]                    avail_o,
  output logic [7:0]                    val_o,
  output logic [3:0]                    taken_o
);

  logic [14:0] acc_q, acc_d;
  logic [3:0]  avail_q, avail_d;
  logic [7:0]  val_q, val_d;
  logic [3:0]  taken_q, taken_d;

  always_comb begin
    acc_d   = acc_q;
    avail_d = avail_q;
    val_d   = val_q;
    taken_d = taken_q;
    if (ctrl_i.load) begin
      acc_d   = {7'b0, pbits_i} | ({7'b0, byte_i} << pcnt_i[2:0]);
      avail_d = 4'd8 + {1'b0, pcnt_i[2:0]};
    end else if (ctrl_i.start) begin
      val_d   = 8'd0;
      taken_d = 4'd0;
    end else if (ctrl_i.shift) begin
      acc_d                = {1'b0, acc_q[14:1]};
      avail_d              = avail_q - 4'd1;
      val_d[taken_q[2:0]]  = acc_q[0];
      taken_d              = taken_q + 4'd1;
    end
  end

  // Pure datapath without reset; the controller reads it only after a load has filled it.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    avail_q <= avail_d;
    val_q   <= val_d;
    taken_q <= taken_d;
  end

  assign acc_lo_o = acc_q[7:0];
  assign avail_o  = avail_q;
  assign val_o    = val_q;
  assign taken_o  = taken_q;

endmodule
`default_nettype wire

### hdl/pbru_divider.sv
// Restoring divider, one quotient bit per cycle, for the fixed-point fraction.
`default_nettype none
`include "packed_bitfield_row_unpacker_top_macros.svh"
module pbru_divider (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [7:0]  dividend_i,
  input  wire  [7:0]  divisor_i,
  output logic        done_o,
  output logic [23:0] quot_o
);

  localparam logic [pbru_pkg::DivCntW-1:0] LastCnt = pbru_pkg::DivCntW'(pbru_pkg::NumW - 1);

  logic [pbru_pkg::NumW-1:0]    nq_q, nq_d;
  logic [7:0]                   rem_q, rem_d;
  logic [7:0]                   div_q, div_d;
  logic [pbru_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [8:0]                   rem_sh;
  logic                         ge;
  logic [8:0]                   rem_sub;
  logic [47:0]                  nq_wide;

  always_comb begin
    rem_sh  = {rem_q, nq_q[pbru_pkg::NumW-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_sub = rem_sh - {1'b0, div_q};
    nq_d    = nq_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      nq_d   = pbru_pkg::NumW'(dividend_i) << pbru_pkg::FracBits;
      rem_d  = 8'd0;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      nq_d  = {nq_q[pbru_pkg::NumW-2:0], ge};
      rem_d = ge ? rem_sub[7:0] : rem_sh[7:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
  end

  assign nq_wide = 48'(nq_q);
  assign quot_o  = nq_wide[23:0];
  assign done_o  = done_q;

  `PBRU_ASSERT_IMP(a_no_restart_busy, start_i, !busy_q)

endmodule
`default_nettype wire

### hdl/packed_bitfield_row_unpacker_top.sv
// Packed bit-field row unpacker: sequencer, configuration registers and output register.
// A byte's results follow group bookkeeping, the bit-serial field shifter and, for a fraction
//   field, the divider; a new byte is taken only once the last one is finished.
// Reset: configuration returns to its reset values, the row waits for a row start, and
//   the output register is empty.
`default_nettype none
`include "packed_bitfield_row_unpacker_top_macros.svh"
module packed_bitfield_row_unpacker_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input channel: one byte of the packed row per transfer.
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  row_byte_i,
  input  wire         row_start_i,
  // Output channel: one decoded field per transfer.
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  raw_value_o,
  output logic [19:0] out_position_o,
  output logic [23:0] scaled_fraction_o,
  output logic [1:0]  field_encoding_o,
  output logic        write_valid_o,
  output logic [1:0]  group_index_o,
  output logic        span_start_o,
  output logic        last_of_byte_o,
  // Configuration write port.
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [24:0] cfg_data_i
);

  // Sequencer states. The two settle states walk the group list one group per
  // cycle: the first one before a byte is used, the second one after it.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SET1    = 4'd1;
  localparam logic [3:0] ST_ACT     = 4'd2;
  localparam logic [3:0] ST_FIELD   = 4'd3;
  localparam logic [3:0] ST_SHIFT   = 4'd4;
  localparam logic [3:0] ST_DIVGO   = 4'd5;
  localparam logic [3:0] ST_DIVWAIT = 4'd6;
  localparam logic [3:0] ST_EMIT    = 4'd7;
  localparam logic [3:0] ST_SET2    = 4'd8;

  // Configuration registers.
  logic [2:0]                    gcount_q;
  logic [pbru_pkg::DescW-1:0]    desc_q [4];

  // Row position state.
  logic [3:0]  state_q, state_d;
  logic [2:0]  grp_q, grp_d;
  logic [9:0]  fld_q, fld_d;
  logic [10:0] skip_q, skip_d;
  logic [7:0]  pbits_q, pbits_d;
  logic [3:0]  pcnt_q, pcnt_d;
  logic [19:0] pos_q, pos_d;
  logic        fin_q, fin_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  nres_q, nres_d;
  logic        adv_grp;

  // Output register.
  logic        ovld_q, ovld_d;
  logic        oload;
  logic [7:0]  o_raw_d;
  logic [19:0] o_pos_d;
  logic [23:0] o_frac_d;
  logic        o_valid_d;
  logic        o_span_d;
  logic        o_last_d;
  logic [7:0]  o_raw_q;
  logic [19:0] o_pos_q;
  logic [23:0] o_frac_q;
  logic [1:0]  o_enc_q;
  logic        o_valid_q;
  logic [1:0]  o_grp_q;
  logic        o_span_q;
  logic        o_last_q;

  // Descriptor of the current group.
  logic [pbru_pkg::DescW-1:0] desc_cur;
  logic [1:0]  enc_c;
  logic [3:0]  bits_c;
  logic [7:0]  max_c;
  logic [9:0]  cnt_c;
  logic        act_c;
  logic [2:0]  used_c;
  logic [13:0] prod_c;
  logic [13:0] prod_rnd;
  logic [10:0] skip_c;
  logic        settle_done;

  // Field shifter and divider.
  pbru_pkg::pbru_fs_ctrl_t fs_ctrl;
  logic [7:0]  fs_acc_lo;
  logic [3:0]  fs_avail;
  logic [7:0]  fs_val;
  logic [3:0]  fs_taken;
  logic        div_start;
  logic        div_done;
  logic [23:0] div_quot;

  logic        more_fields;
  logic        next_exists;
  logic        is_frac_div;
  logic        emits;
  logic        out_free;

  pbru_field_shift u_shift (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fs_ctrl),
    .byte_i   (byte_q),
    .pbits_i  (pbits_q),
    .pcnt_i   (pcnt_q),
    .acc_lo_o (fs_acc_lo),
    .avail_o  (fs_avail),
    .val_o    (fs_val),
    .taken_o  (fs_taken)
  );

  pbru_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (fs_val),
    .divisor_i  (max_c),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Configuration writes take effect at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcount_q <= pbru_pkg::GroupCountReset;
      for (int k = 0; k < 4; k++) begin
        desc_q[k] <= pbru_pkg::DescReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pbru_pkg::CFG_GROUP_COUNT: gcount_q  <= cfg_data_i[2:0];
        pbru_pkg::CFG_DESC_A:      desc_q[0] <= cfg_data_i;
        pbru_pkg::CFG_DESC_B:      desc_q[1] <= cfg_data_i;
        pbru_pkg::CFG_DESC_C:      desc_q[2] <= cfg_data_i;
        pbru_pkg::CFG_DESC_D:      desc_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode the current descriptor. A zero width counts as one bit and widths
  // above eight count as eight.
  always_comb begin
    desc_cur = desc_q[grp_q[1:0]];
    enc_c    = desc_cur[1:0];
    max_c    = desc_cur[13:6];
    cnt_c    = desc_cur[23:14];
    act_c    = desc_cur[24];
    if (desc_cur[5:2] == 4'd0) begin
      bits_c = 4'd1;
    end else if (desc_cur[5:2] > 4'd8) begin
      bits_c = 4'd8;
    end else begin
      bits_c = desc_cur[5:2];
    end
    used_c   = (gcount_q > 3'(pbru_pkg::GroupsMax)) ? 3'(pbru_pkg::GroupsMax) : gcount_q;
    // Bytes an inactive group occupies: ceil(count * bits / 8).
    prod_c   = {4'b0, cnt_c} * {10'b0, bits_c};
    prod_rnd = prod_c + 14'd7;
    skip_c   = prod_rnd[13:3];
  end

  // Loop conditions of the field walk. A later result in this byte exists when
  // the group has another field, enough bits remain and the result limit holds.
  always_comb begin
    more_fields = (fld_q < cnt_c) && (fs_avail >= bits_c) &&
                  (nres_q < 4'(pbru_pkg::MaxResults));
    next_exists = (({1'b0, fld_q} + 11'd1) < {1'b0, cnt_c}) && (fs_avail >= bits_c) &&
                  ((nres_q + 4'd1) < 4'(pbru_pkg::MaxResults));
    is_frac_div = (enc_c == pbru_pkg::ENC_FRACTION) && (max_c != 8'd0);
    emits       = (enc_c != pbru_pkg::ENC_UNKNOWN);
    out_free    = !ovld_q || !out_stall_i;
  end

  always_comb begin
    state_d     = state_q;
    grp_d       = grp_q;
    fld_d       = fld_q;
    skip_d      = skip_q;
    pbits_d     = pbits_q;
    pcnt_d      = pcnt_q;
    pos_d       = pos_q;
    fin_d       = fin_q;
    byte_d      = byte_q;
    nres_d      = nres_q;
    adv_grp     = 1'b0;
    settle_done = 1'b0;
    fs_ctrl     = '0;
    div_start   = 1'b0;
    oload       = 1'b0;
    o_raw_d     = fs_val;
    o_pos_d     = pos_q;
    o_frac_d    = 24'd0;
    o_valid_d   = 1'b1;
    o_span_d    = 1'b0;
    o_last_d    = !next_exists;

    // One step of the group walk: enter groups until one consumes bytes.
    if (fin_q || (skip_q != 11'd0)) begin
      settle_done = 1'b1;
    end else if (grp_q >= used_c) begin
      settle_done = 1'b1;
    end else if (!act_c) begin
      if (skip_c == 11'd0) begin
        adv_grp = 1'b1;
      end else begin
        settle_done = 1'b1;
      end
    end else if (cnt_c == 10'd0) begin
      adv_grp = 1'b1;
    end else begin
      settle_done = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        adv_grp = 1'b0;
        if (in_valid_i) begin
          byte_d  = row_byte_i;
          state_d = ST_SET1;
          if (row_start_i) begin
            grp_d   = 3'd0;
            fld_d   = 10'd0;
            skip_d  = 11'd0;
            pbits_d = 8'd0;
            pcnt_d  = 4'd0;
            pos_d   = 20'd0;
            fin_d   = 1'b0;
          end
        end
      end
      ST_SET1, ST_SET2: begin
        if (!fin_q && (skip_q == 11'd0) && (grp_q >= used_c)) begin
          fin_d = 1'b1;
        end else if (!fin_q && (skip_q == 11'd0) && !act_c && (skip_c != 11'd0)) begin
          skip_d = skip_c;
        end
        if (settle_done) begin
          state_d = (state_q == ST_SET1) ? ST_ACT : ST_IDLE;
        end
      end
      ST_ACT: begin
        adv_grp = 1'b0;
        if (fin_q) begin
          state_d = ST_IDLE;
        end else if (skip_q != 11'd0) begin
          // Inactive group: the byte is consumed without a result.
          skip_d  = skip_q - 11'd1;
          adv_grp = (skip_q == 11'd1);
          state_d = ST_SET2;
        end else begin
          fs_ctrl.load = 1'b1;
          nres_d       = 4'd0;
          state_d      = ST_FIELD;
        end
      end
      ST_FIELD: begin
        adv_grp = 1'b0;
        if (more_fields) begin
          fs_ctrl.start = 1'b1;
          state_d       = ST_SHIFT;
        end else begin
          // Spare bits of a finished group are dropped; otherwise they wait.
          if (fld_q >= cnt_c) begin
            adv_grp = 1'b1;
          end else begin
            pbits_d = fs_acc_lo;
            pcnt_d  = fs_avail;
          end
          state_d = ST_SET2;
        end
      end
      ST_SHIFT: begin
        adv_grp       = 1'b0;
        fs_ctrl.shift = 1'b1;
        if (fs_taken == (bits_c - 4'd1)) begin
          state_d = is_frac_div ? ST_DIVGO : ST_EMIT;
        end
      end
      ST_DIVGO: begin
        adv_grp   = 1'b0;
        div_start = 1'b1;
        state_d   = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        adv_grp = 1'b0;
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        adv_grp = 1'b0;
        if (!emits || out_free) begin
          if (emits) begin
            oload  = 1'b1;
            nres_d = nres_q + 4'd1;
            if (enc_c == pbru_pkg::ENC_ONEHOT) begin
              o_pos_d   = pos_q + 20'(fs_val);
              o_valid_d = (fs_val <= max_c);
              o_span_d  = (fld_q == 10'd0);
              pos_d     = pos_q + 20'(max_c) + 20'd1;
            end else begin
              if (is_frac_div) begin
                o_frac_d = div_quot;
              end
              pos_d = pos_q + 20'd1;
            end
          end
          fld_d   = fld_q + 10'd1;
          state_d = ST_FIELD;
        end
      end
      default: begin
        adv_grp = 1'b0;
        state_d = ST_IDLE;
      end
    endcase

    // Moving on to the next group clears the per-group state.
    if (adv_grp) begin
      grp_d   = grp_q + 3'd1;
      fld_d   = 10'd0;
      pbits_d = 8'd0;
      pcnt_d  = 4'd0;
      skip_d  = 11'd0;
    end

    // The output register empties on a transfer unless a new result enters.
    if (oload) begin
      ovld_d = 1'b1;
    end else if (!out_stall_i) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      grp_q   <= 3'd0;
      fld_q   <= 10'd0;
      skip_q  <= 11'd0;
      pbits_q <= 8'd0;
      pcnt_q  <= 4'd0;
      pos_q   <= 20'd0;
      fin_q   <= 1'b1;
      nres_q  <= 4'd0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      fld_q   <= fld_d;
      skip_q  <= skip_d;
      pbits_q <= pbits_d;
      pcnt_q  <= pcnt_d;
      pos_q   <= pos_d;
      fin_q   <= fin_d;
      nres_q  <= nres_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (oload) begin
      o_raw_q   <= o_raw_d;
      o_pos_q   <= o_pos_d;
      o_frac_q  <= o_frac_d;
      o_enc_q   <= enc_c;
      o_valid_q <= o_valid_d;
      o_grp_q   <= grp_q[1:0];
      o_span_q  <= o_span_d;
      o_last_q  <= o_last_d;
    end
  end

  // A new byte is taken only while no earlier byte is in progress; a finished
  // result may still wait in the output register.
  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = ovld_q;
  assign raw_value_o       = o_raw_q;
  assign out_position_o    = o_pos_q;
  assign scaled_fraction_o = o_frac_q;
  assign field_encoding_o  = o_enc_q;
  assign write_valid_o     = o_valid_q;
  assign group_index_o     = o_grp_q;
  assign span_start_o      = o_span_q;
  assign last_of_byte_o    = o_last_q;

  `PBRU_ASSERT_IMP(a_invalid_only_onehot, out_valid_o && !write_valid_o, field_encoding_o == pbru_pkg::ENC_ONEHOT)
  `PBRU_ASSERT_IMP(a_frac_only_fraction, out_valid_o && (field_encoding_o != pbru_pkg::ENC_FRACTION), scaled_fraction_o == 24'd0)
  `PBRU_ASSERT_NXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o)

endmodule
`default_nettype wire

### sim/tb_packed_bitfield_row_unpacker_top.sv
// Self-checking testbench for the packed bit-field row unpacker.
`timescale 1ns / 100ps

module tb_packed_bitfield_row_unpacker_top;
  import pbru_pkg::*;

  localparam int unsigned ClkHalf      = 5;
  // Cycles to let pass once the last expected field has arrived. A byte may still be in
  // flight that yields no field, and this leaves ample margin for it.
  localparam int unsigned IdleCycles   = 600;
  localparam int unsigned RandomItems  = 500;

  // One decoded field as the block reports it.
  typedef struct packed {
    logic [7:0]  raw;
    logic [19:0] pos;
    logic [23:0] frac;
    logic [1:0]  enc;
    logic        valid;
    logic [1:0]  grp;
    logic        span;
    logic        last;
  } field_result_t;

  typedef enum logic {STEP_WRITE_REG, STEP_SEND_BYTE} step_kind_e;

  // One row of the directed stimulus table. A typed row carries its expected field
  // (or none) written out by hand; every other byte row is checked against the
  // row decoder below.
  typedef struct packed {
    step_kind_e    kind;
    logic [2:0]    reg_index;
    logic [24:0]   reg_data;
    logic [7:0]    data;
    logic          start;
    logic          typed;
    logic          typed_has_field;
    field_result_t typed_field;
  } directed_step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  wire         in_stall;
  logic [7:0]  row_byte;
  logic        row_start;
  wire         out_valid;
  logic        out_stall = 1'b0;
  wire  [7:0]  raw_value;
  wire  [19:0] out_position;
  wire  [23:0] scaled_fraction;
  wire  [1:0]  field_encoding;
  wire         write_valid;
  wire  [1:0]  group_index;
  wire         span_start;
  wire         last_of_byte;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [24:0] cfg_data;

  packed_bitfield_row_unpacker_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .row_byte_i       (row_byte),
    .row_start_i      (row_start),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .raw_value_o      (raw_value),
    .out_position_o   (out_position),
    .scaled_fraction_o(scaled_fraction),
    .field_encoding_o (field_encoding),
    .write_valid_o    (write_valid),
    .group_index_o    (group_index),
    .span_start_o     (span_start),
    .last_of_byte_o   (last_of_byte),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Hard limit on the run. The slowest correct run (every byte giving eight fraction
  // fields, every field waiting out the longest output stall) stays well below this.
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Row decoder: a copy of the configuration and of the decode state, advanced once
  // per accepted byte. Its fields for the latest byte land in decoded_fields.
  // ---------------------------------------------------------------------------------
  logic [2:0]    cfg_groups;
  logic [24:0]   cfg_desc [4];
  logic [2:0]    grp_cur;
  logic [9:0]    fld_idx;
  logic [10:0]   skip_left;
  logic [7:0]    pend_bits;
  logic [3:0]    pend_cnt;
  logic [19:0]   vec_pos;
  logic          row_done;

  field_result_t decoded_fields[$];
  bit            byte_was_ignored;
  field_result_t expected_fields[$];
  int unsigned   fail_count = 0;
  int unsigned   active_items = 0;
  int unsigned   burst_left = 0;

  function automatic logic [24:0] make_desc(logic [1:0] enc, logic [3:0] width,
                                            logic [7:0] mx, logic [9:0] cnt, logic act);
    return {act, cnt, mx, width, enc};
  endfunction

  // A width field of 0 reads as one bit, and anything above 8 as eight bits.
  function automatic int unsigned field_width(logic [24:0] d);
    int unsigned b;
    b = d[5:2];
    if (b == 0) b = 1;
    if (b > 8) b = 8;
    return b;
  endfunction

  function automatic int unsigned groups_in_use();
    int unsigned n;
    n = cfg_groups;
    if (n > GroupsMax) n = GroupsMax;
    return n;
  endfunction

  // Bytes that one well-formed row takes under the present configuration.
  function automatic int unsigned row_length();
    int unsigned total;
    total = 0;
    for (int g = 0; g < groups_in_use(); g++) begin
      total += (cfg_desc[g][23:14] * field_width(cfg_desc[g]) + 7) / 8;
    end
    return total;
  endfunction

  task automatic reset_decoder();
    cfg_groups = GroupCountReset;
    for (int g = 0; g < 4; g++) cfg_desc[g] = DescReset;
    grp_cur   = '0;
    fld_idx   = '0;
    skip_left = '0;
    pend_bits = '0;
    pend_cnt  = '0;
    vec_pos   = '0;
    row_done  = 1'b1;
  endtask

  task automatic enter_next_group();
    grp_cur   = grp_cur + 3'd1;
    fld_idx   = '0;
    pend_bits = '0;
    pend_cnt  = '0;
    skip_left = '0;
  endtask

  // Walk past groups that take no byte until one does, or the row runs out of groups.
  task automatic settle_row();
    logic [24:0] d;
    while (!row_done && skip_left == 0) begin
      if (grp_cur >= groups_in_use()) begin
        row_done = 1'b1;
        break;
      end
      d = cfg_desc[grp_cur[1:0]];
      if (!d[24]) begin
        skip_left = 11'((d[23:14] * field_width(d) + 7) / 8);
        if (skip_left == 0) enter_next_group();
        else break;
      end else if (d[23:14] == 0) begin
        enter_next_group();
      end else begin
        break;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic s);
    logic [24:0]   d;
    logic [1:0]    enc;
    int unsigned   width;
    int unsigned   mx;
    int unsigned   cnt;
    int unsigned   acc;
    int unsigned   avail;
    int unsigned   val;
    longint unsigned quot;
    field_result_t r;
    decoded_fields.delete();
    byte_was_ignored = 1'b0;
    if (s) begin
      grp_cur   = '0;
      fld_idx   = '0;
      skip_left = '0;
      pend_bits = '0;
      pend_cnt  = '0;
      vec_pos   = '0;
      row_done  = 1'b0;
    end
    settle_row();
    if (row_done) begin
      byte_was_ignored = 1'b1;
      return;
    end
    // A byte of an inactive group is simply counted off.
    if (skip_left != 0) begin
      skip_left = skip_left - 11'd1;
      if (skip_left == 0) enter_next_group();
      settle_row();
      return;
    end
    d     = cfg_desc[grp_cur[1:0]];
    enc   = d[1:0];
    width = field_width(d);
    mx    = d[13:6];
    cnt   = d[23:14];
    // Leftover bits of the previous byte sit below the new byte, LSB first.
    acc   = pend_bits | (int'(b) << pend_cnt[2:0]);
    avail = pend_cnt[2:0] + 8;
    while (fld_idx < cnt && avail >= width && decoded_fields.size() < MaxResults) begin
      val   = acc & ((1 << width) - 1);
      acc   = acc >> width;
      avail = avail - width;
      if (enc != ENC_UNKNOWN) begin
        r       = '0;
        r.raw   = val[7:0];
        r.pos   = vec_pos;
        r.enc   = enc;
        r.valid = 1'b1;
        r.grp   = grp_cur[1:0];
        case (enc)
          ENC_FRACTION: begin
            if (mx != 0) begin
              quot   = (longint'(val) << FracBits) / mx;
              r.frac = quot[23:0];
            end
            vec_pos = vec_pos + 20'd1;
          end
          ENC_UNSIGNED: begin
            vec_pos = vec_pos + 20'd1;
          end
          default: begin
            // Onehot: a valid write lands inside the span, and the span is max+1 wide.
            r.pos   = vec_pos + 20'(val);
            r.valid = (val <= mx);
            r.span  = (fld_idx == 0);
            vec_pos = vec_pos + 20'(mx) + 20'd1;
          end
        endcase
        decoded_fields.push_back(r);
      end
      fld_idx = fld_idx + 10'd1;
    end
    if (fld_idx >= cnt) begin
      enter_next_group();
    end else begin
      pend_bits = acc[7:0];
      pend_cnt  = avail[3:0];
    end
    settle_row();
    if (decoded_fields.size() > 0) decoded_fields[decoded_fields.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------
  // Driving side.
  // ---------------------------------------------------------------------------------

  // Registers change only while the block is idle, so the decoder copy is updated at
  // the same edge without any ordering concern.
  task automatic write_cfg(input logic [2:0] idx, input logic [24:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    if (idx == CFG_GROUP_COUNT) cfg_groups = data[2:0];
    else if (idx <= CFG_DESC_D) cfg_desc[idx - CFG_DESC_A] = data;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one byte and returns at the edge that completes its transfer. Bytes go out in
  // bursts; a new burst may be preceded by a gap. When there is no gap, valid simply
  // stays high, so it is never lowered and raised within one time step.
  task automatic send_row_byte(input logic [7:0] b, input logic s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_valid  <= 1'b1;
    row_byte  <= b;
    row_start <= s;
    do @(posedge clk_i); while (in_stall);
    decode_byte(b, s);
    burst_left--;
  endtask

  task automatic queue_decoded_fields();
    foreach (decoded_fields[i]) expected_fields.push_back(decoded_fields[i]);
  endtask

  task automatic send_and_queue(input logic [7:0] b, input logic s);
    send_row_byte(b, s);
    queue_decoded_fields();
    if (!byte_was_ignored) active_items++;
  endtask

  // Called at the edge of the last transfer. A byte that yields no field may still be
  // in the block when the queue runs dry, hence the extra idle cycles.
  task automatic wait_block_idle();
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  function automatic logic [24:0] random_group_count();
    if ($urandom_range(0, 9) == 0) return 25'($urandom_range(0, 7));
    return 25'($urandom_range(1, 4));
  endfunction

  function automatic logic [24:0] random_desc();
    logic [1:0]  enc;
    logic [3:0]  width;
    logic [7:0]  mx;
    logic [9:0]  cnt;
    logic        act;
    int unsigned pick;
    pick  = $urandom_range(0, 99);
    enc   = (pick < 30) ? ENC_FRACTION : (pick < 55) ? ENC_UNSIGNED :
            (pick < 90) ? ENC_ONEHOT : ENC_UNKNOWN;
    width = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(1, 8));
    pick  = $urandom_range(0, 9);
    mx    = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
            (pick < 5) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    pick  = $urandom_range(0, 39);
    if (pick == 0) begin
      // A rare huge group of one-bit fields reaches the top bits of the count.
      cnt   = 10'($urandom_range(512, 1023));
      width = 4'd1;
    end else if (pick < 3) begin
      cnt = 10'd0;
    end else if (pick < 7) begin
      cnt = 10'($urandom_range(13, 48));
    end else begin
      cnt = 10'($urandom_range(1, 12));
    end
    act = ($urandom_range(0, 99) < 85);
    return make_desc(enc, width, mx, cnt, act);
  endfunction

  function automatic logic [7:0] random_row_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Helpers that keep the directed table readable.
  function automatic field_result_t plain_field(logic [7:0] b);
    field_result_t r;
    r       = '0;
    r.raw   = b;
    r.enc   = ENC_UNSIGNED;
    r.valid = 1'b1;
    r.last  = 1'b1;
    return r;
  endfunction

  function automatic directed_step_t cfg_step(logic [2:0] idx, logic [24:0] data);
    return '{STEP_WRITE_REG, idx, data, 8'h00, 1'b0, 1'b0, 1'b0, '0};
  endfunction

  function automatic directed_step_t byte_step(logic [7:0] b, logic s);
    return '{STEP_SEND_BYTE, CFG_GROUP_COUNT, 25'd0, b, s, 1'b0, 1'b0, '0};
  endfunction

  function automatic directed_step_t typed_step(logic [7:0] b, logic s, logic has,
                                                field_result_t f);
    return '{STEP_SEND_BYTE, CFG_GROUP_COUNT, 25'd0, b, s, 1'b1, has, f};
  endfunction

  directed_step_t directed_steps [33];

  // ---------------------------------------------------------------------------------
  // Output side: a stall pattern that switches between running free, random stalls and
  // long stall runs, and a checker that matches each transfer against the oldest
  // expected field.
  // ---------------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_run = 0;
  logic        stall_level = 1'b0;

  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      default: begin
        if (stall_run == 0) begin
          stall_run   = $urandom_range(1, 12);
          stall_level = ~stall_level;
        end
        stall_run--;
        out_stall <= stall_level;
      end
    endcase
  end

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    field_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_fields.size() == 0) begin
        $error("unexpected field: raw_value 0x%0h, out_position 0x%0h, group_index %0d",
               raw_value, out_position, group_index);
        fail_count++;
      end else begin
        want = expected_fields.pop_front();
        compare_field("raw_value", want.raw, raw_value);
        compare_field("out_position", want.pos, out_position);
        compare_field("scaled_fraction", want.frac, scaled_fraction);
        compare_field("field_encoding", want.enc, field_encoding);
        compare_field("write_valid", want.valid, write_valid);
        compare_field("group_index", want.grp, group_index);
        compare_field("span_start", want.span, span_start);
        compare_field("last_of_byte", want.last, last_of_byte);
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------------
  initial begin
    directed_step_t step;
    bit             bytes_since_idle;
    bit             first_phase;
    int unsigned    rows;
    int unsigned    len;
    int unsigned    shape;
    int unsigned    n;

    in_valid  = 1'b0;
    row_byte  = 8'h00;
    row_start = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_GROUP_COUNT;
    cfg_data  = 25'd0;
    rst_ni    = 1'b0;
    reset_decoder();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_steps = '{
      // Reset configuration: one active group holding one 8-bit unsigned field, so a
      // row is a single byte that comes back as it went in.
      typed_step(8'h00, 1'b1, 1'b1, plain_field(8'h00)),
      typed_step(8'hFF, 1'b1, 1'b1, plain_field(8'hFF)),
      // A byte after the row has ended is dropped without a field.
      typed_step(8'hA5, 1'b0, 1'b0, '0),
      // Four groups: two 4-bit fractions, three 3-bit onehot fields straddling a byte,
      // three skipped bytes of an inactive group, and a group of unknown encoding
      // whose zero width reads as one bit.
      cfg_step(CFG_GROUP_COUNT, 25'd4),
      cfg_step(CFG_DESC_A, make_desc(ENC_FRACTION, 4'd4, 8'd15, 10'd2, 1'b1)),
      cfg_step(CFG_DESC_B, make_desc(ENC_ONEHOT, 4'd3, 8'd5, 10'd3, 1'b1)),
      cfg_step(CFG_DESC_C, make_desc(ENC_UNSIGNED, 4'd8, 8'd0, 10'd3, 1'b0)),
      cfg_step(CFG_DESC_D, make_desc(ENC_UNKNOWN, 4'd0, 8'd0, 10'd8, 1'b1)),
      byte_step(8'hF0, 1'b1),
      byte_step(8'hFF, 1'b0),
      byte_step(8'h01, 1'b0),
      byte_step(8'h3C, 1'b0),
      byte_step(8'hC3, 1'b0),
      byte_step(8'h5A, 1'b0),
      byte_step(8'h77, 1'b0),
      typed_step(8'h99, 1'b0, 1'b0, '0),
      // A row start in the middle of a row begins afresh.
      byte_step(8'h0F, 1'b1),
      byte_step(8'hE1, 1'b1),
      // With no groups a row ends at once.
      cfg_step(CFG_GROUP_COUNT, 25'd0),
      typed_step(8'h42, 1'b1, 1'b0, '0),
      // Group count above the number of groups; eight 1-bit fractions with a zero max,
      // an empty active group, an empty inactive group, and a width above eight.
      cfg_step(CFG_GROUP_COUNT, 25'd7),
      cfg_step(CFG_DESC_A, make_desc(ENC_FRACTION, 4'd1, 8'd0, 10'd8, 1'b1)),
      cfg_step(CFG_DESC_B, make_desc(ENC_UNSIGNED, 4'd3, 8'd9, 10'd0, 1'b1)),
      cfg_step(CFG_DESC_C, make_desc(ENC_ONEHOT, 4'd5, 8'd3, 10'd0, 1'b0)),
      cfg_step(CFG_DESC_D, make_desc(ENC_FRACTION, 4'd15, 8'd255, 10'd1, 1'b1)),
      byte_step(8'hFF, 1'b1),
      byte_step(8'h80, 1'b0),
      cfg_step(CFG_DESC_A, 25'd0),
      byte_step(8'h55, 1'b1),
      // Onehot at full width and full max: the largest value is still a valid write.
      cfg_step(CFG_DESC_D, make_desc(ENC_ONEHOT, 4'd8, 8'd255, 10'd1, 1'b1)),
      byte_step(8'hFF, 1'b1),
      // All-ones descriptor: unknown encoding, the longest group.
      cfg_step(CFG_DESC_A, 25'h1FF_FFFF),
      byte_step(8'hFF, 1'b1)
    };

    bytes_since_idle = 1'b0;
    for (int k = 0; k < $size(directed_steps); k++) begin
      step = directed_steps[k];
      if (step.kind == STEP_WRITE_REG) begin
        if (bytes_since_idle) begin
          wait_block_idle();
          bytes_since_idle = 1'b0;
        end
        write_cfg(step.reg_index, step.reg_data);
      end else begin
        send_row_byte(step.data, step.start);
        bytes_since_idle = 1'b1;
        if (!step.typed) queue_decoded_fields();
        else if (step.typed_has_field) expected_fields.push_back(step.typed_field);
      end
    end

    // Random phases: new values for some or all configuration registers, then a few rows.
    // Most rows are exactly as long as the configuration asks; the rest are cut short, run
    // over the end, or are loose bytes with random row starts.
    first_phase = 1'b1;
    while (active_items < RandomItems) begin
      wait_block_idle();
      if (first_phase || $urandom_range(0, 2) != 0) write_cfg(CFG_GROUP_COUNT,
                                                              random_group_count());
      if (first_phase || $urandom_range(0, 2) != 0) write_cfg(CFG_DESC_A, random_desc());
      if (first_phase || $urandom_range(0, 2) != 0) write_cfg(CFG_DESC_B, random_desc());
      if (first_phase || $urandom_range(0, 2) != 0) write_cfg(CFG_DESC_C, random_desc());
      if (first_phase || $urandom_range(0, 2) != 0) write_cfg(CFG_DESC_D, random_desc());
      first_phase = 1'b0;
      rows = $urandom_range(1, 4);
      for (int r = 0; r < rows; r++) begin
        len = row_length();
        if (len == 0) len = 1;
        shape = $urandom_range(0, 9);
        if (shape == 9) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            send_and_queue(random_row_byte(), $urandom_range(0, 7) == 0);
        end else begin
          n = (shape == 7) ? $urandom_range(1, len) :
              (shape == 8) ? len + $urandom_range(1, 3) : len;
          for (int i = 0; i < n; i++) send_and_queue(random_row_byte(), i == 0);
        end
      end
    end

    wait_block_idle();
    if (fail_count == 0 && expected_fields.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
